### hw/rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg: shared types and helpers for the Pauli string product
// Symbol codes, phase codes, per-lane result type and the single-qubit
// Pauli multiply and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

	// symbol codes, 2 bits per qubit
	localparam logic [1:0] P_I = 2'd0;
	localparam logic [1:0] P_X = 2'd1;
	localparam logic [1:0] P_Y = 2'd2;
	localparam logic [1:0] P_Z = 2'd3;

	// powers of i
	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;
	localparam logic [1:0] PH_3 = 2'd3;

	// qubits handled by one lane
	localparam int LANE_Q = 4;

	// width of the coefficient combine path before saturation
	localparam int SUM_W = 34;

	localparam logic signed [SUM_W-1:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [SUM_W-1:0] SAT_MIN = -34'sd2147483648;

	typedef struct packed {
		logic [1:0] sym;
		logic [1:0] ph;
		logic       anti;
	} qubit_res_t;

	typedef struct packed {
		logic [2*LANE_Q-1:0] sym;
		logic [1:0]          ph;
		logic                anti;
	} lane_res_t;

	// cyclic successor: X->Y, Y->Z, Z->X
	function automatic logic [1:0] pauli_next(input logic [1:0] a);
		logic [1:0] n;
		case (a)
			P_X:     n = P_Y;
			P_Y:     n = P_Z;
			default: n = P_X;
		endcase
		return n;
	endfunction

	// single-qubit product with its phase contribution
	function automatic qubit_res_t pauli_mul(input logic [1:0] a, input logic [1:0] b);
		qubit_res_t r;
		r.sym  = a ^ b;
		r.ph   = PH_0;
		r.anti = 1'b0;
		if (a != P_I && b != P_I && a != b) begin
			r.anti = 1'b1;
			r.ph   = (b == pauli_next(a)) ? PH_1 : PH_3;
		end
		return r;
	endfunction

	// clamp to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX)
			r = 32'sh7fffffff;
		else if (v < SAT_MIN)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/pss_lane.sv
// ----------------------------------------------------------------------------
// pss_lane: one lane of the Pauli string multiplier
// Multiplies a group of qubits and reduces their phase and anticommute
// parity to one lane result.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_lane #(
	parameter int ACTIVE = 4
) (
	input  wire logic [2*pss_pkg::LANE_Q-1:0] a_sym,
	input  wire logic [2*pss_pkg::LANE_Q-1:0] b_sym,
	output pss_pkg::lane_res_t                res
);
	import pss_pkg::*;

	// per-qubit multiply, qubits past the string length read as identity
	always_comb begin
		qubit_res_t q;
		q        = '0;
		res.sym  = '0;
		res.ph   = PH_0;
		res.anti = 1'b0;
		for (int j = 0; j < LANE_Q; j++) begin
			if (j < ACTIVE) begin
				q = pauli_mul(a_sym[2*j +: 2], b_sym[2*j +: 2]);
				res.sym[2*j +: 2] = q.sym;
				res.ph            = res.ph + q.ph;
				res.anti          = res.anti ^ q.anti;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pss_merge.sv
// ----------------------------------------------------------------------------
// pss_merge: merging stage of the Pauli string multiplier
// Joins lane results into the product string, phase power and commute
// flag, then applies i^k to the coefficient product and saturates it.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_merge #(
	parameter int LANES = 8,
	parameter int CW    = 16
) (
	input  wire pss_pkg::lane_res_t lane [LANES],
	input  wire logic signed [2*CW-1:0] p_rr,
	input  wire logic signed [2*CW-1:0] p_ii,
	input  wire logic signed [2*CW-1:0] p_ri,
	input  wire logic signed [2*CW-1:0] p_ir,
	output logic [63:0]             prod,
	output logic signed [31:0]      res_re,
	output logic signed [31:0]      res_im,
	output logic [1:0]              k,
	output logic                    comm
);
	import pss_pkg::*;

	localparam int SHIFT = 32 - 2 * CW;

	logic                    anti;
	logic signed [SUM_W-1:0] re;
	logic signed [SUM_W-1:0] im;
	logic signed [SUM_W-1:0] fr;
	logic signed [SUM_W-1:0] fi;

	// gather lane symbols, phase sum mod 4 and parity
	always_comb begin
		prod = '0;
		k    = PH_0;
		anti = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			prod[2*LANE_Q*l +: 2*LANE_Q] = lane[l].sym;
			k    = k + lane[l].ph;
			anti = anti ^ lane[l].anti;
		end
	end

	assign comm = ~anti;

	// complex product scaled to 30 fraction bits
	assign re = (SUM_W'(p_rr) - SUM_W'(p_ii)) <<< SHIFT;
	assign im = (SUM_W'(p_ri) + SUM_W'(p_ir)) <<< SHIFT;

	// multiply by i^k
	always_comb begin
		case (k)
			PH_1: begin
				fr = -im;
				fi = re;
			end
			PH_2: begin
				fr = -re;
				fi = -im;
			end
			PH_3: begin
				fr = im;
				fi = -re;
			end
			default: begin
				fr = re;
				fi = im;
			end
		endcase
	end

	assign res_re = sat32(fr);
	assign res_im = sat32(fi);

endmodule

`default_nettype wire

### hw/rtl/pauli_string_product.sv
// ----------------------------------------------------------------------------
// pauli_string_product: product of two Pauli strings with phase
// Multiplies two strings qubit by qubit in parallel lanes and the two
// complex coefficients, returning product string, i^k, coefficient, flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one string pair and the two
//   coefficients per item. Output channel (out_valid / out_stall) returns
//   one result item per input item, in order.
//   There are two register stages: stage 1 holds the lane results and
//   the four coefficient multiplier outputs, stage 2 is the output
//   register after the lane merge, rotation and saturation.
//   Throughput is one item per cycle while the receiver does not stall;
//   the four multipliers and the lanes each take a new item every cycle
//   in which in_stall is low.
//   When the receiver stalls, the output register holds its item and
//   stage 1 can still take one more item; in_stall rises once both are
//   full. Reset clears both stage valid flags, so no item is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module pauli_string_product #(
	parameter int QUBITS     = 32,
	parameter int COEF_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [63:0]        a_paulis,
	input  wire logic [63:0]        b_paulis,
	input  wire logic signed [15:0] a_re,
	input  wire logic signed [15:0] a_im,
	input  wire logic signed [15:0] b_re,
	input  wire logic signed [15:0] b_im,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [63:0]             product_paulis,
	output logic signed [31:0]      product_re,
	output logic signed [31:0]      product_im,
	output logic [1:0]              phase_power,
	output logic                    commutes
);
	import pss_pkg::*;

	localparam int LANES = (QUBITS + LANE_Q - 1) / LANE_Q;
	localparam int CW    = (COEF_WIDTH < 16) ? COEF_WIDTH : 16;
	localparam int PW    = 2 * CW;

	lane_res_t          lane_c  [LANES];
	lane_res_t          lane_s1 [LANES];
	logic signed [PW-1:0] p_rr_s1;
	logic signed [PW-1:0] p_ii_s1;
	logic signed [PW-1:0] p_ri_s1;
	logic signed [PW-1:0] p_ir_s1;
	logic               v_s1;
	logic               out_valid_q;
	logic               adv2;
	logic               load1;

	logic [63:0]        prod_c;
	logic signed [31:0] re_c;
	logic signed [31:0] im_c;
	logic [1:0]         k_c;
	logic               comm_c;

	logic [63:0]        product_paulis_q;
	logic signed [31:0] product_re_q;
	logic signed [31:0] product_im_q;
	logic [1:0]         phase_power_q;
	logic               commutes_q;

	// pipeline flow control
	assign adv2     = ~out_valid_q | ~out_stall;
	assign load1    = ~v_s1 | adv2;
	assign in_stall = ~load1;

	// qubit lanes
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		localparam int ACT = (QUBITS - l * LANE_Q >= LANE_Q) ? LANE_Q : QUBITS - l * LANE_Q;
		pss_lane #(
			.ACTIVE(ACT)
		) u_lane (
			.a_sym(a_paulis[2*LANE_Q*l +: 2*LANE_Q]),
			.b_sym(b_paulis[2*LANE_Q*l +: 2*LANE_Q]),
			.res  (lane_c[l])
		);
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load1) begin
			v_s1 <= in_valid;
		end
	end

	// stage 1 payload: lane results and coefficient products
	always_ff @(posedge clk) begin
		if (load1 && in_valid) begin
			for (int l = 0; l < LANES; l++)
				lane_s1[l] <= lane_c[l];
			p_rr_s1 <= $signed(a_re[CW-1:0]) * $signed(b_re[CW-1:0]);
			p_ii_s1 <= $signed(a_im[CW-1:0]) * $signed(b_im[CW-1:0]);
			p_ri_s1 <= $signed(a_re[CW-1:0]) * $signed(b_im[CW-1:0]);
			p_ir_s1 <= $signed(a_im[CW-1:0]) * $signed(b_re[CW-1:0]);
		end
	end

	// merge lanes and finish the coefficient
	pss_merge #(
		.LANES(LANES),
		.CW   (CW)
	) u_merge (
		.lane  (lane_s1),
		.p_rr  (p_rr_s1),
		.p_ii  (p_ii_s1),
		.p_ri  (p_ri_s1),
		.p_ir  (p_ir_s1),
		.prod  (prod_c),
		.res_re(re_c),
		.res_im(im_c),
		.k     (k_c),
		.comm  (comm_c)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= v_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			product_paulis_q <= prod_c;
			product_re_q     <= re_c;
			product_im_q     <= im_c;
			phase_power_q    <= k_c;
			commutes_q       <= comm_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign product_paulis = product_paulis_q;
	assign product_re     = product_re_q;
	assign product_im     = product_im_q;
	assign phase_power    = phase_power_q;
	assign commutes       = commutes_q;

	// odd phase power goes with an odd anticommute count
	a_comm_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (commutes == ~phase_power[0]))
		else $error("commute flag disagrees with phase power parity");

	// stage 1 keeps its item while the output side holds
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv2) |=> v_s1)
		else $error("stage 1 item dropped under stall");

	// no symbols past the string length
	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((product_paulis >> (2 * QUBITS)) == 64'd0))
		else $error("product symbols beyond string length");

endmodule

`default_nettype wire
